// ===== hw/rtl/ssrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Shared segment refcount table package
// Types, status codes and the controller state type shared by the block.
// ----------------------------------------------------------------------------
package ssrt_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned REFS_W  = 8;
  localparam int unsigned SLOT_W  = 6;

  localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

  // Request commands.
  localparam logic CMD_OPEN  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT    = 2'd1;
  localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [FRAME_W-1:0] frame;
    logic [REFS_W-1:0]  refs;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SIZE_W-1:0]  map_addr;
    logic [SIZE_W-1:0]  new_size;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  slot;
    logic               released;
  } result_t;

  typedef enum logic [1:0] {
    CTRL_CLEAR,
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_WRITE
  } ctrl_state_t;

endpackage

// ===== hw/rtl/shared_segment_refcount_table.sv =====
// ----------------------------------------------------------------------------
// Shared segment refcount table
// Table of shared memory segments with open/close reference counting.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_valid/in_ready channel with cmd (open or close),
// seg_id, proc_size, alloc_frame and alloc_ok. Each request produces exactly
// one result on the out_valid/out_ready channel: status, map_addr, new_size,
// frame, slot and released.
// The table lives in a synchronous memory with a registered read port.
// Each request reads every entry in index order to find the first matching
// id and the first free entry, then writes the chosen entry back, if any.
// The scan sweeps the single read port over every entry; one request is in
// flight at a time, and the controller writes back and returns to idle
// before it accepts the next request.
// After reset the controller clears the table one entry per cycle, so
// in_ready stays low until every entry is cleared.
// Results are held in an output register. A new request can be accepted
// while a finished result waits there; if the receiver still stalls when the
// next result is ready, the controller holds it, and its write-back, until
// the output register frees.
// ----------------------------------------------------------------------------
module shared_segment_refcount_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PAGE_SHIFT    = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] seg_id,
  input  logic [30:0] proc_size,
  input  logic [19:0] alloc_frame,
  input  logic        alloc_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [30:0] map_addr,
  output logic [30:0] new_size,
  output logic [19:0] frame,
  output logic [5:0]  slot,
  output logic        released
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  ssrt_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  ssrt_pkg::entry_t  mem_rdata;

  logic              res_free;
  logic              res_push;
  ssrt_pkg::result_t res;
  ssrt_pkg::result_t out_q;

  // The output register can take a new result when it is empty or when its
  // current result leaves this cycle.
  assign res_free = !out_valid || out_ready;

  ssrt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssrt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT),
    .AW            (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (in_valid),
    .req_ready       (in_ready),
    .req_cmd         (cmd),
    .req_seg_id      (seg_id),
    .req_proc_size   (proc_size),
    .req_alloc_frame (alloc_frame),
    .req_alloc_ok    (alloc_ok),
    .res_free        (res_free),
    .res_push        (res_push),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  // Result register: valid is control state, the payload loads on push.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign status   = out_q.status;
  assign map_addr = out_q.map_addr;
  assign new_size = out_q.new_size;
  assign frame    = out_q.frame;
  assign slot     = out_q.slot;
  assign released = out_q.released;

`ifndef ASSERT_OFF
  // A request is followed by a scan, so the block cannot take another one
  // in the very next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a scan was starting");

  // A failed request reports neither a frame nor a slot.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ssrt_pkg::STATUS_OK) |-> (frame == '0 && slot == '0))
    else $error("error result carries frame or slot");

  // Only a successful close can release an entry, and it maps nothing.
  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && released) |-> (status == ssrt_pkg::STATUS_OK && map_addr == '0))
    else $error("release flagged on a failed or open request");

  // Mapping addresses are always page aligned.
  a_map_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (map_addr[PAGE_SHIFT-1:0] == '0))
    else $error("map address not page aligned");
`endif

endmodule

// ===== hw/rtl/ssrt_mem.sv =====
// ----------------------------------------------------------------------------
// Segment table memory
// Single-port-write, single-port-read table with a registered read port.
// ----------------------------------------------------------------------------
module ssrt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ssrt_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output ssrt_pkg::entry_t rdata
);

  ssrt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ssrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segment table controller
// Clears the table after reset, scans it for each request and writes back any chosen entry.
// ----------------------------------------------------------------------------
module ssrt_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PAGE_SHIFT    = 12,
  parameter int unsigned AW            = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           req_cmd,
  input  logic [ssrt_pkg::ID_W-1:0]      req_seg_id,
  input  logic [ssrt_pkg::SIZE_W-1:0]    req_proc_size,
  input  logic [ssrt_pkg::FRAME_W-1:0]   req_alloc_frame,
  input  logic                           req_alloc_ok,
  input  logic                           res_free,
  output logic                           res_push,
  output ssrt_pkg::result_t              res,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output ssrt_pkg::entry_t               mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  ssrt_pkg::entry_t               mem_rdata
);

  localparam logic [AW:0]   CNT_END  = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_ENTRIES - 1);
  localparam logic [ssrt_pkg::SIZE_W-1:0] PAGE_BYTES =
    ssrt_pkg::SIZE_W'(1) << PAGE_SHIFT;
  localparam logic [ssrt_pkg::SIZE_W-1:0] PAGE_MASK = PAGE_BYTES - 1'b1;

  ssrt_pkg::ctrl_state_t state, state_next;

  logic [AW:0]   cnt;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;

  logic                           q_cmd;
  logic [ssrt_pkg::ID_W-1:0]      q_seg_id;
  logic [ssrt_pkg::SIZE_W-1:0]    q_proc_size;
  logic [ssrt_pkg::FRAME_W-1:0]   q_alloc_frame;
  logic                           q_alloc_ok;

  logic                           hit_found;
  logic [AW-1:0]                  hit_idx;
  logic [ssrt_pkg::ID_W-1:0]      hit_id;
  logic [ssrt_pkg::FRAME_W-1:0]   hit_frame;
  logic [ssrt_pkg::REFS_W-1:0]    hit_refs;
  logic                           free_found;
  logic [AW-1:0]                  free_idx;

  logic [ssrt_pkg::SIZE_W-1:0]    aligned;
  logic                           wb_en;
  logic [AW-1:0]                  wb_addr;
  ssrt_pkg::entry_t               wb_data;
  ssrt_pkg::result_t              wb_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ssrt_pkg::CTRL_CLEAR;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ssrt_pkg::CTRL_CLEAR: begin
          cnt <= cnt + 1'b1;
        end
        ssrt_pkg::CTRL_IDLE: begin
          if (req_valid) begin
            cnt        <= '0;
            rd_pend    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        ssrt_pkg::CTRL_SCAN: begin
          if (cnt < CNT_END) begin
            cnt <= cnt + 1'b1;
          end
          rd_pend <= (cnt < CNT_END);
          if (rd_pend) begin
            if (!hit_found && mem_rdata.id == q_seg_id) begin
              hit_found <= 1'b1;
            end
            if (!free_found && mem_rdata.id == '0) begin
              free_found <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request and scan payload.
  always_ff @(posedge clk) begin
    if (state == ssrt_pkg::CTRL_IDLE && req_valid) begin
      q_cmd         <= req_cmd;
      q_seg_id      <= req_seg_id;
      q_proc_size   <= req_proc_size;
      q_alloc_frame <= req_alloc_frame;
      q_alloc_ok    <= req_alloc_ok;
    end
    if (state == ssrt_pkg::CTRL_SCAN) begin
      rd_idx <= cnt[AW-1:0];
      if (rd_pend && !hit_found && mem_rdata.id == q_seg_id) begin
        hit_idx   <= rd_idx;
        hit_id    <= mem_rdata.id;
        hit_frame <= mem_rdata.frame;
        hit_refs  <= mem_rdata.refs;
      end
      if (rd_pend && !free_found && mem_rdata.id == '0) begin
        free_idx <= rd_idx;
      end
    end
  end

  // Write-back and result for the finished scan.
  always_comb begin
    aligned         = (q_proc_size + PAGE_MASK) & ~PAGE_MASK;
    wb_en           = 1'b0;
    wb_addr         = hit_idx;
    wb_data         = '0;
    wb_res          = '0;
    wb_res.new_size = q_proc_size;
    if (q_cmd == ssrt_pkg::CMD_OPEN) begin
      if (hit_found) begin
        wb_en         = 1'b1;
        wb_data.id    = hit_id;
        wb_data.frame = hit_frame;
        wb_data.refs  = (hit_refs == ssrt_pkg::REFS_MAX) ? hit_refs : hit_refs + 1'b1;
        wb_res.status   = ssrt_pkg::STATUS_OK;
        wb_res.map_addr = aligned;
        wb_res.frame    = hit_frame;
        wb_res.slot     = ssrt_pkg::SLOT_W'(hit_idx);
      end else if (!free_found) begin
        wb_res.status = ssrt_pkg::STATUS_NO_SLOT;
      end else if (!q_alloc_ok) begin
        wb_res.status = ssrt_pkg::STATUS_ALLOC_FAIL;
      end else begin
        wb_en           = 1'b1;
        wb_addr         = free_idx;
        wb_data.id      = q_seg_id;
        wb_data.frame   = q_alloc_frame;
        wb_data.refs    = ssrt_pkg::REFS_W'(1);
        wb_res.status   = ssrt_pkg::STATUS_OK;
        wb_res.map_addr = aligned;
        wb_res.new_size = aligned + PAGE_BYTES;
        wb_res.frame    = q_alloc_frame;
        wb_res.slot     = ssrt_pkg::SLOT_W'(free_idx);
      end
    end else begin
      if (!hit_found) begin
        wb_res.status = ssrt_pkg::STATUS_NOT_FOUND;
      end else begin
        wb_en         = 1'b1;
        wb_res.status = ssrt_pkg::STATUS_OK;
        wb_res.frame  = hit_frame;
        wb_res.slot   = ssrt_pkg::SLOT_W'(hit_idx);
        if (hit_refs > ssrt_pkg::REFS_W'(1)) begin
          wb_data.id    = hit_id;
          wb_data.frame = hit_frame;
          wb_data.refs  = hit_refs - 1'b1;
        end else begin
          wb_res.released = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssrt_pkg::CTRL_CLEAR: begin
        if (cnt[AW-1:0] == IDX_LAST) begin
          state_next = ssrt_pkg::CTRL_IDLE;
        end
      end
      ssrt_pkg::CTRL_IDLE: begin
        if (req_valid) begin
          state_next = ssrt_pkg::CTRL_SCAN;
        end
      end
      ssrt_pkg::CTRL_SCAN: begin
        if (rd_pend && rd_idx == IDX_LAST) begin
          state_next = ssrt_pkg::CTRL_WRITE;
        end
      end
      ssrt_pkg::CTRL_WRITE: begin
        if (res_free) begin
          state_next = ssrt_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_next = ssrt_pkg::CTRL_CLEAR;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_push  = 1'b0;
    res       = wb_res;
    mem_we    = 1'b0;
    mem_waddr = wb_addr;
    mem_wdata = wb_data;
    mem_re    = 1'b0;
    mem_raddr = cnt[AW-1:0];
    case (state)
      ssrt_pkg::CTRL_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = '0;
      end
      ssrt_pkg::CTRL_IDLE: begin
        req_ready = 1'b1;
      end
      ssrt_pkg::CTRL_SCAN: begin
        mem_re = (cnt < CNT_END);
      end
      ssrt_pkg::CTRL_WRITE: begin
        res_push = res_free;
        mem_we   = res_free && wb_en;
      end
      default: begin
      end
    endcase
  end

endmodule
